// ===== sv/crkv_pkg.sv =====
package crkv_pkg;

  localparam int SlotsDef = 32;
  localparam int KeyW     = 64;
  localparam int ValW     = 64;
  localparam int LenW     = 4;
  localparam int CntW     = 32;
  localparam int MaxBytes = 8;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [LenW-1:0] len;
  } entry_t;

  // Saturate a byte count at eight.
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] n);
    return (n > LenW'(MaxBytes)) ? LenW'(MaxBytes) : n;
  endfunction

  // Keep the low n bytes of a value.
  function automatic logic [ValW-1:0] byte_mask(input logic [LenW-1:0] n);
    logic [ValW-1:0] m;
    m = '0;
    for (int b = 0; b < MaxBytes; b++) begin
      m[8*b +: 8] = (LenW'(b) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== sv/crkv_store.sv =====
module crkv_store #(
  parameter int Slots = crkv_pkg::SlotsDef
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Slots)-1:0] rd_addr_i,
  output crkv_pkg::entry_t         rd_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Slots)-1:0] wr_addr_i,
  input  crkv_pkg::entry_t         wr_i
);
  import crkv_pkg::*;

  logic [KeyW-1:0] key_mem [Slots];
  logic [ValW-1:0] val_mem [Slots];
  logic [LenW-1:0] len_mem [Slots];

  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_i.key;
      val_mem[wr_addr_i] <= wr_i.value;
      len_mem[wr_addr_i] <= wr_i.len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.key   <= key_mem[rd_addr_i];
      rd_q.value <= val_mem[rd_addr_i];
      rd_q.len   <= len_mem[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// ===== sv/clock_replacement_kv_cache.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   operation_i key_i value_i value_bytes_i
// out      out_valid_o / out_stall_i status_o data_o data_bytes_o hit_total_o miss_total_o
//
// One item at a time. For a get or a put, until a hit or the last slot, the
// key compare walks the entry memory one slot per cycle through its read port.
// A put that misses then runs a clock-hand sweep, one slot a cycle. A zero-length put
// skips the compare and returns invalid. Reset clears valid and reference marks, hand and
// counters at once; a slot's entry takes part in a compare only once its valid mark is set.
// A stalled result holds in the output register; the next item is taken meanwhile.
module clock_replacement_kv_cache #(
  parameter int Slots = crkv_pkg::SlotsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [crkv_pkg::KeyW-1:0] key_i,
  input  logic [crkv_pkg::ValW-1:0] value_i,
  input  logic [crkv_pkg::LenW-1:0] value_bytes_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [crkv_pkg::ValW-1:0] data_o,
  output logic [crkv_pkg::LenW-1:0] data_bytes_o,
  output logic [crkv_pkg::CntW-1:0] hit_total_o,
  output logic [crkv_pkg::CntW-1:0] miss_total_o
);
  import crkv_pkg::*;

  localparam int IdxW = $clog2(Slots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Slots - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [Slots-1:0] valid_q, valid_d, ref_q, ref_d;
  logic [IdxW-1:0]  hand_q, hand_d;
  logic [CntW-1:0]  hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d;

  logic [IdxW-1:0]  idx_q, idx_d, cmp_idx_q, cmp_idx_d;
  logic             issue_q, issue_d, cmp_vld_q, cmp_vld_d;

  op_e              op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [ValW-1:0]  val_q, val_d;
  logic [LenW-1:0]  len_q, len_d;

  status_e          res_st_q, res_st_d;
  logic [ValW-1:0]  res_data_q, res_data_d;
  logic [LenW-1:0]  res_len_q, res_len_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_st_q, out_st_d;
  logic [ValW-1:0]  out_data_q, out_data_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic [CntW-1:0]  out_hit_q, out_hit_d, out_miss_q, out_miss_d;

  logic             rd_en, wr_en;
  logic [IdxW-1:0]  wr_addr;
  entry_t           rd_ent, wr_ent;

  logic             key_hit, scan_last, out_free;
  logic [LenW-1:0]  in_len, ret_len;

  crkv_store #(.Slots(Slots)) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_o      (rd_ent),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_i      (wr_ent)
  );

  assign in_len    = clamp_len(value_bytes_i);
  assign ret_len   = (len_q < rd_ent.len) ? len_q : rd_ent.len;
  assign key_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (rd_ent.key == key_q);
  assign scan_last = cmp_vld_q && (cmp_idx_q == LastIdx);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_en     = (state_q == S_SCAN) && issue_q;

  assign wr_ent.key   = key_q;
  assign wr_ent.value = val_q & byte_mask(len_q);
  assign wr_ent.len   = len_q;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    ref_d      = ref_q;
    hand_d     = hand_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    idx_d      = idx_q;
    issue_d    = issue_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    len_d      = len_q;
    res_st_d   = res_st_q;
    res_data_d = res_data_q;
    res_len_d  = res_len_q;
    wr_en      = 1'b0;
    wr_addr    = cmp_idx_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_st_d    = out_st_q;
    out_data_d  = out_data_q;
    out_len_d   = out_len_q;
    out_hit_d   = out_hit_q;
    out_miss_d  = out_miss_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_e'(operation_i);
          key_d      = key_i;
          val_d      = value_i;
          len_d      = in_len;
          res_data_d = '0;
          res_len_d  = '0;
          res_st_d   = ST_OK;
          if (op_e'(operation_i) == OP_PUT && in_len == '0) begin
            res_st_d = ST_INVALID;
            state_d  = S_DONE;
          end else begin
            idx_d   = '0;
            issue_d = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while comparing the previous one
        if (issue_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
          if (idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (key_hit) begin
          ref_d[cmp_idx_q] = 1'b1;
          issue_d          = 1'b0;
          state_d          = S_DONE;
          if (op_q == OP_GET) begin
            res_data_d = rd_ent.value & byte_mask(ret_len);
            res_len_d  = ret_len;
            hit_cnt_d  = hit_cnt_q + 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end else if (scan_last) begin
          if (op_q == OP_GET) begin
            res_st_d   = ST_MISS;
            miss_cnt_d = miss_cnt_q + 1'b1;
            state_d    = S_DONE;
          end else begin
            state_d = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        hand_d = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
        if (!valid_q[hand_q] || !ref_q[hand_q]) begin
          wr_en           = 1'b1;
          wr_addr         = hand_q;
          valid_d[hand_q] = 1'b1;
          ref_d[hand_q]   = 1'b1;
          state_d         = S_DONE;
        end else begin
          ref_d[hand_q] = 1'b0;
        end
      end
      S_DONE: begin
        // hold until the output register can take the item
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_data_d  = res_data_q;
          out_len_d   = res_len_q;
          out_hit_d   = hit_cnt_q;
          out_miss_d  = miss_cnt_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      ref_q       <= '0;
      hand_q      <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ref_q       <= ref_d;
      hand_q      <= hand_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    len_q      <= len_d;
    res_st_q   <= res_st_d;
    res_data_q <= res_data_d;
    res_len_q  <= res_len_d;
    out_st_q   <= out_st_d;
    out_data_q <= out_data_d;
    out_len_q  <= out_len_d;
    out_hit_q  <= out_hit_d;
    out_miss_q <= out_miss_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign data_o       = out_data_q;
  assign data_bytes_o = out_len_q;
  assign hit_total_o  = out_hit_q;
  assign miss_total_o = out_miss_q;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crkv_pkg::*;

  localparam int Slots       = SlotsDef;
  localparam int NumDirected = 20;
  localparam int NumRandom   = 1500;
  localparam int PoolDepth   = 64;
  localparam int CycleLimit  = 1_000_000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] data;
    logic [LenW-1:0] nbytes;
    logic [CntW-1:0] hits;
    logic [CntW-1:0] misses;
  } reply_t;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [LenW-1:0] nbytes;
    bit              fixed;
    reply_t          typed_r;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic operation_i;
  logic [KeyW-1:0] key_i;
  logic [ValW-1:0] value_i;
  logic [LenW-1:0] value_bytes_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] status_o;
  logic [ValW-1:0] data_o;
  logic [LenW-1:0] data_bytes_o;
  logic [CntW-1:0] hit_total_o;
  logic [CntW-1:0] miss_total_o;

  // Shadow copy of the cache contents
  logic [KeyW-1:0] slot_key   [Slots];
  logic [ValW-1:0] slot_value [Slots];
  int              slot_len   [Slots];
  bit              slot_valid [Slots];
  bit              slot_ref   [Slots];
  int              hand_pos;
  logic [CntW-1:0] hit_count;
  logic [CntW-1:0] miss_count;

  reply_t pending_replies[$];
  int     error_count = 0;
  int     cycle_count = 0;
  bit     idle_on = 1'b0;

  // Hit rows are typed in only where the bytes are plain to see.
  stim_row_t directed_rows [NumDirected] = '{
    '{OP_GET, 64'h0, 64'h0, 4'd8, 1'b1, '{ST_MISS, 64'h0, 4'd0, 32'd0, 32'd1}},
    '{OP_PUT, 64'h0, AllOnes, 4'd0, 1'b1, '{ST_INVALID, 64'h0, 4'd0, 32'd0, 32'd1}},
    '{OP_GET, 64'h0, 64'h0, 4'd8, 1'b1, '{ST_MISS, 64'h0, 4'd0, 32'd0, 32'd2}},
    '{OP_PUT, 64'h0, AllOnes, 4'd8, 1'b1, '{ST_OK, 64'h0, 4'd0, 32'd0, 32'd2}},
    '{OP_GET, 64'h0, 64'h0, 4'd15, 1'b1, '{ST_OK, AllOnes, 4'd8, 32'd1, 32'd2}},
    '{OP_PUT, AllOnes, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b1,
      '{ST_OK, 64'h0, 4'd0, 32'd1, 32'd2}},
    '{OP_GET, AllOnes, AllOnes, 4'd8, 1'b1, '{ST_OK, 64'hAB_CDEF, 4'd3, 32'd2, 32'd2}},
    '{OP_GET, AllOnes, 64'h0, 4'd1, 1'b1, '{ST_OK, 64'hEF, 4'd1, 32'd3, 32'd2}},
    '{OP_GET, AllOnes, 64'h0, 4'd0, 1'b1, '{ST_OK, 64'h0, 4'd0, 32'd4, 32'd2}},
    '{OP_PUT, 64'h0, 64'h8000_0000_0000_0001, 4'd12, 1'b0, '0},
    '{OP_GET, 64'h0, 64'h0, 4'd15, 1'b0, '0},
    '{OP_PUT, 64'h8000_0000_0000_0000, AllOnes, 4'd7, 1'b0, '0},
    '{OP_GET, 64'h8000_0000_0000_0000, 64'h0, 4'd8, 1'b0, '0},
    '{OP_GET, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 4'd8, 1'b0, '0},
    '{OP_PUT, AllOnes, 64'hFEDC_BA98_7654_3210, 4'd1, 1'b0, '0},
    '{OP_GET, AllOnes, 64'h0, 4'd8, 1'b0, '0},
    '{OP_PUT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 4'd9, 1'b0, '0},
    '{OP_GET, 64'h5555_5555_5555_5555, 64'h0, 4'd4, 1'b0, '0},
    '{OP_PUT, 64'h1, 64'h0, 4'd15, 1'b0, '0},
    '{OP_GET, 64'h1, 64'h0, 4'd2, 1'b0, '0}
  };

  clock_replacement_kv_cache #(.Slots(Slots)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .value_bytes_i(value_bytes_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .data_o       (data_o),
    .data_bytes_o (data_bytes_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic logic [ValW-1:0] keep_bytes(input logic [ValW-1:0] v, input int n);
    return (n >= MaxBytes) ? v : v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // Apply one item to the shadow cache and return the reply it produces.
  function automatic reply_t cache_predict(input op_e op, input logic [KeyW-1:0] k,
                                           input logic [ValW-1:0] v,
                                           input logic [LenW-1:0] n);
    reply_t r;
    int len;
    int found;
    int s;
    r = '0;
    r.status = ST_OK;
    len = (n > LenW'(MaxBytes)) ? MaxBytes : int'(n);
    found = -1;
    // Scan downward so the lowest matching slot wins.
    for (int i = Slots - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == k) found = i;
    end
    if (op == OP_GET) begin
      if (found < 0) begin
        miss_count++;
        r.status = ST_MISS;
      end else begin
        s = (len < slot_len[found]) ? len : slot_len[found];
        r.data   = keep_bytes(slot_value[found], s);
        r.nbytes = LenW'(s);
        slot_ref[found] = 1'b1;
        hit_count++;
      end
    end else if (len == 0) begin
      r.status = ST_INVALID;
    end else begin
      if (found < 0) begin
        // Second chance: clear set marks until a free or unmarked slot turns up.
        for (int t = 0; t < 2 * Slots; t++) begin
          s = hand_pos;
          hand_pos = (hand_pos + 1) % Slots;
          if (!slot_valid[s] || !slot_ref[s]) begin
            found = s;
            break;
          end
          slot_ref[s] = 1'b0;
        end
        slot_key[found]   = k;
        slot_valid[found] = 1'b1;
      end
      slot_value[found] = keep_bytes(v, len);
      slot_len[found]   = len;
      slot_ref[found]   = 1'b1;
    end
    r.hits   = hit_count;
    r.misses = miss_count;
    return r;
  endfunction

  // Present one item, hold it through any stall, and record what it should return.
  task automatic send_item(input op_e op, input logic [KeyW-1:0] k,
                           input logic [ValW-1:0] v, input logic [LenW-1:0] n,
                           input bit fixed, input reply_t typed_r);
    int gap;
    reply_t r;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    key_i         <= k;
    value_i       <= v;
    value_bytes_i <= n;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = cache_predict(op, k, v, n);
    pending_replies.push_back(fixed ? typed_r : r);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report_error("result with nothing expected");
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("data", data_o, want.data);
        check_field("data_bytes", 64'(data_bytes_o), 64'(want.nbytes));
        check_field("hit_total", 64'(hit_total_o), 64'(want.hits));
        check_field("miss_total", 64'(miss_total_o), 64'(want.misses));
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [KeyW-1:0] key_pool [PoolDepth];
    int pool_size;
    op_e op;
    logic [KeyW-1:0] k;
    logic [ValW-1:0] v;
    logic [LenW-1:0] n;
    stim_row_t row;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = OP_GET;
    key_i         = '0;
    value_i       = '0;
    value_bytes_i = '0;
    foreach (slot_valid[i]) begin
      slot_valid[i] = 1'b0;
      slot_ref[i]   = 1'b0;
    end
    hand_pos   = 0;
    hit_count  = '0;
    miss_count = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    pool_size = 4;

    repeat (10) @(negedge clk_i);
    rst_ni  = 1'b1;
    idle_on = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.op, row.key, row.value, row.nbytes, row.fixed, row.typed_r);
    end

    // Working sets below, near and above the slot count exercise hits,
    // second-chance sweeps and steady eviction.
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: pool_size = 4;
          1: pool_size = 24;
          2: pool_size = 40;
          default: pool_size = PoolDepth;
        endcase
      end
      idle_on = (i < NumRandom - 200) && ((i / 100) % 4 != 3);
      op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
      k = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(0, pool_size - 1)];
      case ($urandom_range(0, 7))
        0: v = '0;
        1: v = AllOnes;
        default: v = {$urandom, $urandom};
      endcase
      if (op == OP_PUT && $urandom_range(0, 15) != 0) begin
        n = LenW'($urandom_range(1, 15));
      end else begin
        n = LenW'($urandom_range(0, 15));
      end
      send_item(op, k, v, n, 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (3 * Slots + 16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
